/* hw/rtl/cstat_pkg.sv */
// Shared types, counter indexes and state codes for the I/O call statistics block.
package cstat_pkg;

    localparam int CSTAT_NUM_COUNTERS = 19;
    localparam int CTR_W              = 64;
    localparam int IDX_W              = 5;
    localparam int DIV_STEPS          = 64;

    typedef logic [IDX_W-1:0] ctr_idx_t;

    localparam ctr_idx_t CTR_RD_BYTES = 5'd0;
    localparam ctr_idx_t CTR_RD_CALLS = 5'd1;
    localparam ctr_idx_t CTR_RD_ERR   = 5'd2;
    localparam ctr_idx_t CTR_RD_INTR  = 5'd3;
    localparam ctr_idx_t CTR_RD_WBLK  = 5'd4;
    localparam ctr_idx_t CTR_RD_SHORT = 5'd5;
    localparam ctr_idx_t CTR_RD_EOF   = 5'd6;
    localparam ctr_idx_t CTR_RD_MEAN  = 5'd7;
    localparam ctr_idx_t CTR_RD_USEC  = 5'd8;
    localparam ctr_idx_t CTR_WR_BYTES = 5'd9;
    localparam ctr_idx_t CTR_WR_CALLS = 5'd10;
    localparam ctr_idx_t CTR_WR_ERR   = 5'd11;
    localparam ctr_idx_t CTR_WR_SHORT = 5'd12;
    localparam ctr_idx_t CTR_WR_MEAN  = 5'd13;
    localparam ctr_idx_t CTR_WR_USEC  = 5'd14;
    localparam ctr_idx_t CTR_OP_CALLS = 5'd15;
    localparam ctr_idx_t CTR_OP_ERR   = 5'd16;
    localparam ctr_idx_t CTR_OP_FDS   = 5'd17;

    typedef enum logic [2:0] {
        FN_OPEN   = 3'd0,
        FN_READ   = 3'd1,
        FN_IREAD  = 3'd2,
        FN_WRITE  = 3'd3,
        FN_IWRITE = 3'd4,
        FN_CLEAR  = 3'd5,
        FN_QUERY  = 3'd6
    } func_t;

    localparam logic [1:0] CAUSE_INTR = 2'd1;
    localparam logic [1:0] CAUSE_WBLK = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic [31:0]        item_size;
        logic [31:0]        item_count;
        logic signed [32:0] returned;
        logic [1:0]         error_cause;
        logic               at_eof;
        logic [31:0]        duration_us;
        logic [4:0]         counter_select;
    } item_t;

    typedef struct packed {
        logic             we;
        logic             clr;
        ctr_idx_t         addr;
        logic [CTR_W-1:0] wdata;
    } bank_cmd_t;

    typedef struct packed {
        logic             load;
        ctr_idx_t         id;
        logic [CTR_W-1:0] value;
    } query_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_OPEN,
        S_CALLS,
        S_INC1,
        S_INC2,
        S_MREQ,
        S_MBYTES,
        S_BYTES,
        S_SHORT,
        S_USEC,
        S_PROD0,
        S_PROD1,
        S_PROD2,
        S_PROD3,
        S_PROD4,
        S_DIV,
        S_CLEAR,
        S_QUERY
    } seq_state_t;

endpackage

/* hw/rtl/cstat_evt_if.sv */
// Event channel: one call event, clear or query per transaction.
interface cstat_evt_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [31:0]        item_size;
    logic [31:0]        item_count;
    logic signed [32:0] returned;
    logic [1:0]         error_cause;
    logic               at_eof;
    logic [31:0]        duration_us;
    logic [4:0]         counter_select;

    modport source (
        output valid, func, item_size, item_count, returned, error_cause, at_eof,
               duration_us, counter_select,
        input  ready
    );
    modport sink (
        input  valid, func, item_size, item_count, returned, error_cause, at_eof,
               duration_us, counter_select,
        output ready
    );
endinterface

/* hw/rtl/cstat_rsp_if.sv */
// Response channel: one counter readout per transaction.
interface cstat_rsp_if;
    logic        valid;
    logic        ready;
    logic [4:0]  counter_id;
    logic [63:0] counter_value;

    modport source (
        output valid, counter_id, counter_value,
        input  ready
    );
    modport sink (
        input  valid, counter_id, counter_value,
        output ready
    );
endinterface

/* hw/rtl/cstat_bank.sv */
// Counter register file: one read port, one write port, bulk clear.
module cstat_bank
    import cstat_pkg::*;
#(
    parameter int NUM_COUNTERS = CSTAT_NUM_COUNTERS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bank_cmd_t        cmd,
    input  ctr_idx_t         rd_addr,
    output logic [CTR_W-1:0] rd_data
);

    localparam int              ADDR_W  = $clog2(NUM_COUNTERS);
    localparam logic [IDX_W:0]  NUM_LIM = NUM_COUNTERS[IDX_W:0];

    logic [CTR_W-1:0] bank_reg [NUM_COUNTERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= '{default: '0};
        end
        else if (cmd.clr)
        begin
            bank_reg <= '{default: '0};
        end
        else if (cmd.we && ({1'b0, cmd.addr} < NUM_LIM))
        begin
            bank_reg[cmd.addr[ADDR_W-1:0]] <= cmd.wdata;
        end
    end

    // out-of-range selects read as zero
    always_comb
    begin
        if ({1'b0, rd_addr} < NUM_LIM)
        begin
            rd_data = bank_reg[rd_addr[ADDR_W-1:0]];
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

/* hw/rtl/cstat_div.sv */
// Restoring 64-bit divider, one quotient bit per cycle.
module cstat_div
    import cstat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CTR_W-1:0] dividend,
    input  logic [CTR_W-1:0] divisor,
    output logic             done,
    output logic [CTR_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CTR_W-1:0] q_reg;
    logic [CTR_W-1:0] r_reg;
    logic [CTR_W-1:0] d_reg;

    logic [CTR_W:0]   shifted;
    logic [CTR_W:0]   diff;
    logic [CTR_W-1:0] q_next;
    logic [CTR_W-1:0] r_next;

    always_comb
    begin
        shifted = {r_reg, q_reg[CTR_W-1]};
        diff    = shifted - {1'b0, d_reg};
        if (!diff[CTR_W])
        begin
            r_next = diff[CTR_W-1:0];
            q_next = {q_reg[CTR_W-2:0], 1'b1};
        end
        else
        begin
            r_next = shifted[CTR_W-1:0];
            q_next = {q_reg[CTR_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* hw/rtl/cstat_seq.sv */
// Sequencer: decodes an event and drives the shared multiplier, adder and divider.
module cstat_seq
    import cstat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  item_t            item,
    output logic             ready,
    input  logic             out_free,
    output query_t           query,
    output bank_cmd_t        cmd,
    output ctr_idx_t         rd_addr,
    input  logic [CTR_W-1:0] rd_data,
    output logic             div_start,
    output logic [CTR_W-1:0] div_dividend,
    output logic [CTR_W-1:0] div_divisor,
    input  logic             div_done,
    input  logic [CTR_W-1:0] div_quotient
);

    typedef enum logic [1:0] {
        WD_INC,
        WD_PROD,
        WD_DUR,
        WD_QUOT
    } wsel_t;

    seq_state_t state_reg, state_next;

    logic             wr_reg;
    logic             itm_reg;
    logic             ok_reg;
    ctr_idx_t         inc1_reg;
    logic             inc2_vld_reg;
    ctr_idx_t         inc2_reg;
    logic [31:0]      size_reg;
    logic [31:0]      count_reg;
    logic [31:0]      ret_reg;
    logic [31:0]      dur_reg;
    ctr_idx_t         sel_reg;
    logic [CTR_W-1:0] n_reg;
    logic [CTR_W-1:0] req_reg;
    logic [CTR_W-1:0] mul_reg;
    logic [CTR_W-1:0] acc_reg;

    logic             dec_neg;
    logic             dec_pos;
    logic             dec_wr;
    logic             dec_itm;
    logic             dec_ok;
    ctr_idx_t         dec_inc1;
    logic             dec_inc2_vld;
    ctr_idx_t         dec_inc2;

    ctr_idx_t         calls_idx;
    ctr_idx_t         bytes_idx;
    ctr_idx_t         short_idx;
    ctr_idx_t         mean_idx;
    ctr_idx_t         usec_idx;

    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [CTR_W-1:0] prod;
    logic [31:0]      scale;
    wsel_t            wsel;
    logic [CTR_W-1:0] addend;
    logic             cmd_we;
    logic             cmd_clr;
    logic             query_load;

    // event decode at acceptance
    always_comb
    begin
        dec_neg      = item.returned[32];
        dec_pos      = !dec_neg && (item.returned[31:0] != 32'd0);
        dec_wr       = 1'b0;
        dec_itm      = 1'b0;
        dec_ok       = 1'b0;
        dec_inc1     = CTR_OP_FDS;
        dec_inc2_vld = 1'b0;
        dec_inc2     = (item.error_cause == CAUSE_INTR) ? CTR_RD_INTR : CTR_RD_WBLK;
        case (func_t'(item.func))
            FN_OPEN:
            begin
                dec_inc1 = dec_neg ? CTR_OP_ERR : CTR_OP_FDS;
            end
            FN_READ:
            begin
                dec_ok       = dec_pos;
                dec_inc1     = dec_neg ? CTR_RD_ERR : CTR_RD_EOF;
                dec_inc2_vld = dec_neg && ((item.error_cause == CAUSE_INTR) ||
                                           (item.error_cause == CAUSE_WBLK));
            end
            FN_IREAD:
            begin
                dec_itm  = 1'b1;
                dec_ok   = dec_pos;
                dec_inc1 = (!dec_neg && item.at_eof) ? CTR_RD_EOF : CTR_RD_ERR;
            end
            FN_WRITE:
            begin
                dec_wr   = 1'b1;
                dec_ok   = !dec_neg;
                dec_inc1 = CTR_WR_ERR;
            end
            FN_IWRITE:
            begin
                dec_wr   = 1'b1;
                dec_itm  = 1'b1;
                dec_ok   = dec_pos;
                dec_inc1 = CTR_WR_ERR;
            end
            default:
            begin
                dec_ok = 1'b0;
            end
        endcase
    end

    assign calls_idx = wr_reg ? CTR_WR_CALLS : CTR_RD_CALLS;
    assign bytes_idx = wr_reg ? CTR_WR_BYTES : CTR_RD_BYTES;
    assign short_idx = wr_reg ? CTR_WR_SHORT : CTR_RD_SHORT;
    assign mean_idx  = wr_reg ? CTR_WR_MEAN  : CTR_RD_MEAN;
    assign usec_idx  = wr_reg ? CTR_WR_USEC  : CTR_RD_USEC;
    assign scale     = itm_reg ? size_reg : 32'd1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (func_t'(item.func))
                        FN_OPEN:   state_next = S_OPEN;
                        FN_READ:   state_next = S_CALLS;
                        FN_IREAD:  state_next = S_CALLS;
                        FN_WRITE:  state_next = S_CALLS;
                        FN_IWRITE: state_next = S_CALLS;
                        FN_CLEAR:  state_next = S_CLEAR;
                        FN_QUERY:  state_next = S_QUERY;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_OPEN:   state_next = S_INC1;
            S_CALLS:  state_next = ok_reg ? S_MREQ : S_INC1;
            S_INC1:   state_next = inc2_vld_reg ? S_INC2 : S_IDLE;
            S_INC2:   state_next = S_IDLE;
            S_MREQ:   state_next = S_MBYTES;
            S_MBYTES: state_next = S_BYTES;
            S_BYTES:  state_next = S_SHORT;
            S_SHORT:  state_next = S_USEC;
            // n+1 wraps to zero: mean stays as it is
            S_USEC:   state_next = (&n_reg) ? S_IDLE : S_PROD0;
            S_PROD0:  state_next = S_PROD1;
            S_PROD1:  state_next = S_PROD2;
            S_PROD2:  state_next = S_PROD3;
            S_PROD3:  state_next = S_PROD4;
            S_PROD4:  state_next = S_DIV;
            S_DIV:    state_next = div_done ? S_IDLE : S_DIV;
            S_CLEAR:  state_next = S_IDLE;
            S_QUERY:  state_next = out_free ? S_IDLE : S_QUERY;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ready      = 1'b0;
        rd_addr    = mean_idx;
        cmd_we     = 1'b0;
        cmd_clr    = 1'b0;
        wsel       = WD_INC;
        div_start  = 1'b0;
        query_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                ready = 1'b1;
            end
            S_OPEN:
            begin
                rd_addr = CTR_OP_CALLS;
                cmd_we  = 1'b1;
            end
            S_CALLS:
            begin
                rd_addr = calls_idx;
                cmd_we  = 1'b1;
            end
            S_INC1:
            begin
                rd_addr = inc1_reg;
                cmd_we  = 1'b1;
            end
            S_INC2:
            begin
                rd_addr = inc2_reg;
                cmd_we  = 1'b1;
            end
            S_BYTES:
            begin
                rd_addr = bytes_idx;
                cmd_we  = 1'b1;
                wsel    = WD_PROD;
            end
            S_SHORT:
            begin
                rd_addr = short_idx;
                cmd_we  = (ret_reg < count_reg);
            end
            S_USEC:
            begin
                rd_addr = usec_idx;
                cmd_we  = 1'b1;
                wsel    = WD_DUR;
            end
            S_PROD4:
            begin
                div_start = 1'b1;
            end
            S_DIV:
            begin
                cmd_we = div_done;
                wsel   = WD_QUOT;
            end
            S_CLEAR:
            begin
                cmd_clr = 1'b1;
            end
            S_QUERY:
            begin
                rd_addr    = sel_reg;
                query_load = out_free;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

    // multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MREQ:
            begin
                mul_a = count_reg;
                mul_b = scale;
            end
            S_MBYTES:
            begin
                mul_a = ret_reg;
                mul_b = scale;
            end
            // low 64 bits of n*mean from three 32x32 partial products
            S_PROD0:
            begin
                mul_a = n_reg[31:0];
                mul_b = rd_data[31:0];
            end
            S_PROD1:
            begin
                mul_a = n_reg[31:0];
                mul_b = rd_data[63:32];
            end
            S_PROD2:
            begin
                mul_a = n_reg[63:32];
                mul_b = rd_data[31:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = {32'd0, mul_a} * {32'd0, mul_b};

    always_comb
    begin
        case (wsel)
            WD_INC:  addend = 64'd1;
            WD_PROD: addend = mul_reg;
            WD_DUR:  addend = {32'd0, dur_reg};
            default: addend = '0;
        endcase
    end

    assign cmd = '{we:    cmd_we,
                   clr:   cmd_clr,
                   addr:  rd_addr,
                   wdata: (wsel == WD_QUOT) ? div_quotient : (rd_data + addend)};
    assign query = '{load: query_load, id: sel_reg, value: rd_data};
    assign div_dividend = acc_reg + req_reg;
    assign div_divisor  = n_reg + 64'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            wr_reg       <= dec_wr;
            itm_reg      <= dec_itm;
            ok_reg       <= dec_ok;
            inc1_reg     <= dec_inc1;
            inc2_vld_reg <= dec_inc2_vld;
            inc2_reg     <= dec_inc2;
            size_reg     <= item.item_size;
            count_reg    <= item.item_count;
            ret_reg      <= item.returned[31:0];
            dur_reg      <= item.duration_us;
            sel_reg      <= item.counter_select;
        end
        case (state_reg)
            S_CALLS:
            begin
                n_reg <= rd_data;
            end
            S_MREQ:
            begin
                req_reg <= prod;
            end
            S_MBYTES, S_PROD0:
            begin
                mul_reg <= prod;
            end
            S_PROD1:
            begin
                acc_reg <= mul_reg;
                mul_reg <= prod;
            end
            S_PROD2:
            begin
                acc_reg <= acc_reg + {mul_reg[31:0], 32'd0};
                mul_reg <= prod;
            end
            S_PROD3:
            begin
                acc_reg <= acc_reg + {mul_reg[31:0], 32'd0};
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_div_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROD4) |=> ((state_reg == S_DIV) && !div_done))
        else $error("divider finished too early");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("transaction accepted while busy");

    a_query_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QUERY) && !out_free |=> (state_reg == S_QUERY))
        else $error("query left without a free response slot");
`endif

endmodule

/* hw/rtl/io_call_statistics_counters.sv */
// Top level of the I/O call statistics counter bank.
//
//   channel  role    transaction
//   evt      sink    one call event, clear or query
//   rsp      source  counter id and value, for queries only
//
// Open, failed transfer, empty one but a plain write: call and outcome counters only.
// Successful transfer: also bytes, short, usec and mean; mean via the 64-step divider.
// Clear and query: a query is held longer while rsp is stalled.
// evt.ready is high only between transactions; the response register frees the sequencer.
// rst_n clears the counters at once; no clearing pass.
module io_call_statistics_counters
    import cstat_pkg::*;
#(
    parameter int NUM_COUNTERS = CSTAT_NUM_COUNTERS
) (
    input  logic         clk,
    input  logic         rst_n,
    cstat_evt_if.sink    evt,
    cstat_rsp_if.source  rsp
);

    item_t            item;
    logic             start;
    logic             ready;
    logic             out_free;
    query_t           query;
    bank_cmd_t        cmd;
    ctr_idx_t         rd_addr;
    logic [CTR_W-1:0] rd_data;
    logic             div_start;
    logic [CTR_W-1:0] div_dividend;
    logic [CTR_W-1:0] div_divisor;
    logic             div_done;
    logic [CTR_W-1:0] div_quotient;

    logic             out_valid_reg;
    ctr_idx_t         out_id_reg;
    logic [CTR_W-1:0] out_value_reg;

    assign item.func           = evt.func;
    assign item.item_size      = evt.item_size;
    assign item.item_count     = evt.item_count;
    assign item.returned       = evt.returned;
    assign item.error_cause    = evt.error_cause;
    assign item.at_eof         = evt.at_eof;
    assign item.duration_us    = evt.duration_us;
    assign item.counter_select = evt.counter_select;

    assign evt.ready = ready;
    assign start     = evt.valid && ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    cstat_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .ready        (ready),
        .out_free     (out_free),
        .query        (query),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient)
    );

    cstat_bank #(
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cstat_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (query.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query.load)
        begin
            out_id_reg    <= query.id;
            out_value_reg <= query.value;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.counter_id    = out_id_reg;
    assign rsp.counter_value = out_value_reg;

endmodule
